/* rtl/core/v3au_pkg.sv */
package v3au_pkg;

   localparam int WORD_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LANES      = 3;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIV_W      = WORD_W + FRAC_BITS;
   localparam int SQ_REM_W   = WORD_W + 1;
   localparam int SQRT_CELLS = WORD_W;
   localparam int DIV_CELLS  = DIV_W;

   // opcodes
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_ADD_S = 4'd4;
   localparam logic [3:0] OP_SUB_S = 4'd5;
   localparam logic [3:0] OP_MUL_S = 4'd6;
   localparam logic [3:0] OP_DIV_S = 4'd7;
   localparam logic [3:0] OP_SUM   = 4'd8;
   localparam logic [3:0] OP_DOT   = 4'd9;
   localparam logic [3:0] OP_MAGSQ = 4'd10;
   localparam logic [3:0] OP_MAG   = 4'd11;
   localparam logic [3:0] OP_NORM  = 4'd12;

   // what is still to be done to a beat in the chain
   localparam logic [1:0] KIND_EARLY = 2'd0;
   localparam logic [1:0] KIND_DIV   = 2'd1;
   localparam logic [1:0] KIND_MAG   = 2'd2;
   localparam logic [1:0] KIND_NORM  = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]                        kind;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][WORD_W-1:0]      er;
      word_type                          es;
      logic                              edz;
      logic [PROD_W-1:0]                 rad;
      logic [SQ_REM_W-1:0]               sq_rem;
      word_type                          root;
      logic [LANES-1:0][WORD_W-1:0]      dvsr;
      logic [LANES-1:0][WORD_W-1:0]      drem;
      logic [LANES-1:0][DIV_W-1:0]       work;
   } pipe_type;

   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0]      r;
      word_type                          s;
      logic                              dz;
   } res_type;

   function automatic word_type sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
      lo = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
      if (v > hi) return WORD_MAX;
      if (v < lo) return WORD_MIN;
      return v[WORD_W-1:0];
   endfunction

endpackage

/* rtl/core/v3au_front.sv */
module v3au_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [3:0]                          in_op,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_a_x,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_a_y,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_a_z,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_b_x,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_b_y,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_b_z,
   input  logic signed [v3au_pkg::WORD_W-1:0]  in_scalar,
   output logic                                out_valid,
   output v3au_pkg::pipe_type                  out_pipe
);
   import v3au_pkg::*;

   function automatic word_type abs_word(input word_type v);
      return v[WORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   logic signed [WORD_W-1:0] a_in [LANES];
   logic signed [WORD_W-1:0] b_in [LANES];
   logic signed [WORD_W-1:0] m_in [LANES];
   logic signed [PROD_W-1:0] p_in [LANES];
   logic                     bcast;
   logic                     square;

   logic                     s1_valid_ff;
   logic [3:0]               s1_op_ff;
   logic signed [WORD_W-1:0] s1_a_ff [LANES];
   logic signed [WORD_W-1:0] s1_b_ff [LANES];
   logic signed [PROD_W-1:0] s1_p_ff [LANES];

   logic signed [SUM_W-1:0]  psum;
   logic signed [SUM_W-1:0]  asum;
   logic                     any_b_zero;
   pipe_type                 pipe_in;
   pipe_type                 pipe_ff;
   logic                     valid_ff;

   // stage 1: broadcast and the three lane multipliers
   always_comb begin
      a_in[0] = in_a_x;
      a_in[1] = in_a_y;
      a_in[2] = in_a_z;
      bcast   = (in_op >= OP_ADD_S) && (in_op <= OP_DIV_S);
      square  = (in_op == OP_MAGSQ) || (in_op == OP_MAG) || (in_op == OP_NORM);
      b_in[0] = bcast ? in_scalar : in_b_x;
      b_in[1] = bcast ? in_scalar : in_b_y;
      b_in[2] = bcast ? in_scalar : in_b_z;
      for (int i = 0; i < LANES; i++) begin
         m_in[i] = square ? a_in[i] : b_in[i];
         p_in[i] = PROD_W'(a_in[i]) * PROD_W'(m_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         valid_ff    <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff <= in_op;
         for (int i = 0; i < LANES; i++) begin
            s1_a_ff[i] <= a_in[i];
            s1_b_ff[i] <= b_in[i];
            s1_p_ff[i] <= p_in[i];
         end
         pipe_ff <= pipe_in;
      end
   end

   // stage 2: sums, saturation, set-up for root and divide cells
   always_comb begin
      psum = SUM_W'(s1_p_ff[0]) + SUM_W'(s1_p_ff[1]) + SUM_W'(s1_p_ff[2]);
      asum = SUM_W'(s1_a_ff[0]) + SUM_W'(s1_a_ff[1]) + SUM_W'(s1_a_ff[2]);
      any_b_zero = (s1_b_ff[0] == '0) || (s1_b_ff[1] == '0) || (s1_b_ff[2] == '0);

      pipe_in        = '0;
      pipe_in.kind   = KIND_EARLY;
      pipe_in.rad    = psum[PROD_W-1:0];
      for (int i = 0; i < LANES; i++) begin
         pipe_in.neg[i]  = s1_a_ff[i][WORD_W-1] ^ s1_b_ff[i][WORD_W-1];
         pipe_in.dvsr[i] = abs_word(s1_b_ff[i]);
         pipe_in.work[i] = {abs_word(s1_a_ff[i]), {FRAC_BITS{1'b0}}};
      end

      unique case (s1_op_ff)
         OP_ADD, OP_ADD_S: begin
            for (int i = 0; i < LANES; i++)
               pipe_in.er[i] = sat_word(SUM_W'(s1_a_ff[i]) + SUM_W'(s1_b_ff[i]));
         end
         OP_SUB, OP_SUB_S: begin
            for (int i = 0; i < LANES; i++)
               pipe_in.er[i] = sat_word(SUM_W'(s1_a_ff[i]) - SUM_W'(s1_b_ff[i]));
         end
         OP_MUL, OP_MUL_S: begin
            for (int i = 0; i < LANES; i++)
               pipe_in.er[i] = sat_word(SUM_W'(s1_p_ff[i]) >>> FRAC_BITS);
         end
         OP_DIV, OP_DIV_S: begin
            if (any_b_zero) pipe_in.edz  = 1'b1;
            else            pipe_in.kind = KIND_DIV;
         end
         OP_SUM:            pipe_in.es = sat_word(asum);
         OP_DOT, OP_MAGSQ:  pipe_in.es = sat_word(psum >>> FRAC_BITS);
         OP_MAG:            pipe_in.kind = KIND_MAG;
         OP_NORM: begin
            pipe_in.kind = KIND_NORM;
            for (int i = 0; i < LANES; i++)
               pipe_in.neg[i] = s1_a_ff[i][WORD_W-1];
         end
         default: ;  // spare codes give all zeros
      endcase
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

/* rtl/core/v3au_sqrt_cell.sv */
module v3au_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  v3au_pkg::pipe_type in_pipe,
   output logic               out_valid,
   output v3au_pkg::pipe_type out_pipe
);
   import v3au_pkg::*;

   logic [SQ_REM_W+1:0] trem;
   logic [SQ_REM_W+1:0] trial;
   logic [SQ_REM_W+1:0] diff;
   logic                ge;
   pipe_type            pipe_in;
   pipe_type            pipe_ff;
   logic                valid_ff;

   // one root bit per cell, two radicand bits in
   always_comb begin
      trem    = {in_pipe.sq_rem, in_pipe.rad[PROD_W-1 -: 2]};
      trial   = (SQ_REM_W+2)'({in_pipe.root, 2'b01});
      diff    = trem - trial;
      ge      = trem >= trial;
      pipe_in = in_pipe;
      pipe_in.sq_rem = ge ? diff[SQ_REM_W-1:0] : trem[SQ_REM_W-1:0];
      pipe_in.root   = {in_pipe.root[WORD_W-2:0], ge};
      pipe_in.rad    = {in_pipe.rad[PROD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset)   valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

/* rtl/core/v3au_div_cell.sv */
module v3au_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  v3au_pkg::pipe_type in_pipe,
   output logic               out_valid,
   output v3au_pkg::pipe_type out_pipe
);
   import v3au_pkg::*;

   logic [WORD_W:0] trem [LANES];
   logic [WORD_W:0] dext [LANES];
   logic [WORD_W:0] diff [LANES];
   logic            ge   [LANES];
   pipe_type        pipe_in;
   pipe_type        pipe_ff;
   logic            valid_ff;

   // one restoring quotient bit per lane per cell
   always_comb begin
      pipe_in = in_pipe;
      for (int i = 0; i < LANES; i++) begin
         trem[i] = {in_pipe.drem[i], in_pipe.work[i][DIV_W-1]};
         dext[i] = {1'b0, in_pipe.dvsr[i]};
         diff[i] = trem[i] - dext[i];
         ge[i]   = trem[i] >= dext[i];
         pipe_in.drem[i] = ge[i] ? diff[i][WORD_W-1:0] : trem[i][WORD_W-1:0];
         pipe_in.work[i] = {in_pipe.work[i][DIV_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

/* rtl/core/v3au_back.sv */
module v3au_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  v3au_pkg::pipe_type                 in_pipe,
   output logic                               chain_en,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_x,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_y,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_z,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_scalar_out,
   output logic                               rsp_div_zero
);
   import v3au_pkg::*;

   localparam logic [DIV_W-1:0] Q_POS_LIM = DIV_W'(WORD_MAX);
   localparam logic [DIV_W-1:0] Q_NEG_LIM = DIV_W'(WORD_MIN);

   res_type  res;
   res_type  out_ff;
   res_type  skid_ff;
   logic     out_valid_ff;
   logic     skid_valid_ff;
   logic     take;
   logic     drain;
   word_type qv [LANES];

   // sign and saturate the quotients, pick the result
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (in_pipe.neg[i]) begin
            if (in_pipe.work[i] > Q_NEG_LIM) qv[i] = WORD_MIN;
            else                             qv[i] = ~in_pipe.work[i][WORD_W-1:0] + 1'b1;
         end else begin
            if (in_pipe.work[i] > Q_POS_LIM) qv[i] = WORD_MAX;
            else                             qv[i] = in_pipe.work[i][WORD_W-1:0];
         end
         res.r[i] = (in_pipe.kind == KIND_DIV) ? qv[i] : in_pipe.er[i];
      end
      res.s  = in_pipe.es;
      res.dz = in_pipe.edz;
   end

   assign chain_en = !skid_valid_ff;
   assign take     = in_valid && !skid_valid_ff;
   assign drain    = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         out_valid_ff  <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain)          out_ff  <= skid_valid_ff ? skid_ff : res;
      if (!drain && take) skid_ff <= res;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_r_x        = out_ff.r[0];
   assign rsp_r_y        = out_ff.r[1];
   assign rsp_r_z        = out_ff.r[2];
   assign rsp_scalar_out = out_ff.s;
   assign rsp_div_zero   = out_ff.dz;

endmodule

/* rtl/core/vec3_arith_unit_top.sv */
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// req      | req_valid/req_ready  | req_op, req_a_*, req_b_*, req_scalar_in
// rsp      | rsp_valid/rsp_ready  | rsp_r_*, rsp_scalar_out, rsp_div_zero
//
// One beat in per cycle while req_ready is high, one beat out per cycle while
// rsp_ready is high; a beat passes the front stages, one root bit per cell, one
// quotient bit per cell and the output register. The divide chain length is WORD_W + FRAC_BITS.
// Reset (synchronous) clears only the valid bits; no clearing pass.
// A stalled result sits in the output register while a second beat lands in
// the skid register; req_ready drops only while the skid register is full,
// and then the whole chain holds.
module vec3_arith_unit_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [3:0]                         req_op,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_a_x,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_a_y,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_a_z,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_b_x,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_b_y,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_b_z,
   input  logic signed [v3au_pkg::WORD_W-1:0] req_scalar_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_x,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_y,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_r_z,
   output logic signed [v3au_pkg::WORD_W-1:0] rsp_scalar_out,
   output logic                               rsp_div_zero
);
   import v3au_pkg::*;

   logic     adv;
   logic     sq_valid [SQRT_CELLS+1];
   pipe_type sq_pipe  [SQRT_CELLS+1];
   logic     dv_valid [DIV_CELLS+1];
   pipe_type dv_pipe  [DIV_CELLS+1];

   // chain moves as one; held only while the skid register is occupied
   assign req_ready = adv;

   v3au_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_op     (req_op),
      .in_a_x    (req_a_x),
      .in_a_y    (req_a_y),
      .in_a_z    (req_a_z),
      .in_b_x    (req_b_x),
      .in_b_y    (req_b_y),
      .in_b_z    (req_b_z),
      .in_scalar (req_scalar_in),
      .out_valid (sq_valid[0]),
      .out_pipe  (sq_pipe[0])
   );

   // integer square root of the sum of squares, MSB first
   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      v3au_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[g]),
         .in_pipe   (sq_pipe[g]),
         .out_valid (sq_valid[g+1]),
         .out_pipe  (sq_pipe[g+1])
      );
   end

   // root done: magnitude is final, normalize takes the root as divisor
   always_comb begin
      dv_valid[0] = sq_valid[SQRT_CELLS];
      dv_pipe[0]  = sq_pipe[SQRT_CELLS];
      if (sq_pipe[SQRT_CELLS].kind == KIND_MAG) begin
         dv_pipe[0].kind = KIND_EARLY;
         dv_pipe[0].es   = sq_pipe[SQRT_CELLS].root[WORD_W-1] ? WORD_MAX
                                                              : sq_pipe[SQRT_CELLS].root;
      end else if (sq_pipe[SQRT_CELLS].kind == KIND_NORM) begin
         if (sq_pipe[SQRT_CELLS].root == '0) begin
            // zero vector: flag and zeros
            dv_pipe[0].kind = KIND_EARLY;
            dv_pipe[0].edz  = 1'b1;
         end else begin
            dv_pipe[0].kind = KIND_DIV;
            for (int i = 0; i < LANES; i++)
               dv_pipe[0].dvsr[i] = sq_pipe[SQRT_CELLS].root;
         end
      end
   end

   // restoring divide, one quotient bit per cell on all three lanes
   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      v3au_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[g]),
         .in_pipe   (dv_pipe[g]),
         .out_valid (dv_valid[g+1]),
         .out_pipe  (dv_pipe[g+1])
      );
   end

   v3au_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (dv_valid[DIV_CELLS]),
      .in_pipe        (dv_pipe[DIV_CELLS]),
      .chain_en       (adv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_r_x        (rsp_r_x),
      .rsp_r_y        (rsp_r_y),
      .rsp_r_z        (rsp_r_z),
      .rsp_scalar_out (rsp_scalar_out),
      .rsp_div_zero   (rsp_div_zero)
   );

endmodule

/* rtl/core/v3au_checker.sv */
module v3au_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [v3au_pkg::WORD_W-1:0] rsp_r_x,
   input logic signed [v3au_pkg::WORD_W-1:0] rsp_r_y,
   input logic signed [v3au_pkg::WORD_W-1:0] rsp_r_z,
   input logic signed [v3au_pkg::WORD_W-1:0] rsp_scalar_out,
   input logic                               rsp_div_zero
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r_x) && $stable(rsp_r_y)
         && $stable(rsp_r_z) && $stable(rsp_scalar_out) && $stable(rsp_div_zero))
      else $error("result beat changed while stalled");

   // the flag comes with zeros everywhere else
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |->
         rsp_r_x == 0 && rsp_r_y == 0 && rsp_r_z == 0 && rsp_scalar_out == 0)
      else $error("divide-by-zero beat carries data");

   // input held off only with a result waiting
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // ready comes back after the output is taken
   a_ready_back: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_ready |=> req_ready)
      else $error("input still stalled after output drained");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind vec3_arith_unit_top v3au_checker u_v3au_checker (.*);
